### rtl/tbl_pkg.sv
package tbl_pkg;

    localparam int LEVEL_W     = 32;
    localparam int RATE_W      = 32;
    localparam int BURST_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int TIME_BITS_DEFAULT = 48;
    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 32'h0001_0000;
    localparam logic [BURST_W-1:0] BURST_RESET = 16'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RATE  = 2'd0,
        CFG_BURST = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_per_tick;
        logic [BURST_W-1:0] burst_size;
    } tbl_cfg_t;

endpackage

### rtl/tbl_cfg_regs.sv
module tbl_cfg_regs
    import tbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output tbl_cfg_t               cfg
);

    tbl_cfg_t cfg_reg;
    tbl_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATE:  cfg_next.rate_per_tick = cfg_data[RATE_W-1:0];
                CFG_BURST: cfg_next.burst_size    = cfg_data[BURST_W-1:0];
                default:   cfg_next = cfg_reg; // ignore unknown registers
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_per_tick <= RATE_RESET;
            cfg_reg.burst_size    <= BURST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/tbl_refill.sv
module tbl_refill
    import tbl_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  tbl_cfg_t             cfg,
    input  logic [TIME_BITS-1:0] now,
    input  logic [TIME_BITS-1:0] last_grant_time,
    input  logic [LEVEL_W-1:0]   token_level,
    output logic                 grant,
    output logic [LEVEL_W-1:0]   level_next
);

    localparam int CAP_W = BURST_W + FRAC_BITS;
    localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(1) << FRAC_BITS;

    logic [CAP_W-1:0]          cap_wide;
    logic                      cap_over;
    logic [LEVEL_W-1:0]        cap;
    logic [LEVEL_W-1:0]        room;
    logic [TIME_BITS-1:0]      elapsed;
    logic                      elapsed_big;
    logic [LEVEL_W-1:0]        elapsed_lo;
    logic [2*LEVEL_W-1:0]      gain;
    logic                      fill;
    logic [LEVEL_W-1:0]        level_ref;

    assign cap_wide = {cfg.burst_size, {FRAC_BITS{1'b0}}};

    generate
        if (CAP_W > LEVEL_W)
        begin : g_cap_wide
            assign cap_over = |cap_wide[CAP_W-1:LEVEL_W];
        end
        else
        begin : g_cap_narrow
            assign cap_over = 1'b0;
        end
    endgenerate

    always_comb
    begin
        if (cfg.burst_size == '0 || cap_over)
            cap = LEVEL_MAX;
        else
            cap = LEVEL_W'(cap_wide);
    end

    assign room    = cap - token_level;
    // hold elapsed at zero when the clock appears to run backwards
    assign elapsed = (now > last_grant_time) ? now - last_grant_time : '0;

    generate
        if (TIME_BITS > LEVEL_W)
        begin : g_time_wide
            assign elapsed_big = |elapsed[TIME_BITS-1:LEVEL_W];
            assign elapsed_lo  = elapsed[LEVEL_W-1:0];
        end
        else
        begin : g_time_narrow
            assign elapsed_big = 1'b0;
            assign elapsed_lo  = LEVEL_W'(elapsed);
        end
    endgenerate

    assign gain = {{LEVEL_W{1'b0}}, elapsed_lo} * {{LEVEL_W{1'b0}}, cfg.rate_per_tick};

    assign fill = (cfg.rate_per_tick == '0) || (token_level >= cap) || elapsed_big
                  || (gain >= {{LEVEL_W{1'b0}}, room});

    assign level_ref  = fill ? cap : token_level + gain[LEVEL_W-1:0];
    assign grant      = (level_ref >= ONE_TOKEN);
    assign level_next = level_ref - ONE_TOKEN;

endmodule

### rtl/token_bucket_limiter_unit.sv
// Token bucket policer. Each request transfer carries a timestamp in ticks; the
// block answers every request with one result transfer whose allowed bit says
// whether a token was taken. Tokens accrue at rate_per_tick (fixed point with
// FRAC_BITS fraction bits) for the ticks since the last granted request and are
// capped at burst_size whole tokens; a rate of zero refills the bucket at once
// and a burst of zero gives the largest 32-bit capacity. A timestamp older than
// the last grant counts as no elapsed time. A refused request leaves the bucket
// untouched. Requests go through an input register and a result register; a
// new request is taken every cycle while the result channel is not stalled,
// and the combinational refill path (one 32x32 multiply, an add and the
// capacity compares) reads and updates the bucket state. Write the
// configuration only while no request is in flight.
module token_bucket_limiter_unit
    import tbl_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [TIME_BITS-1:0]   request_time,
    // result channel
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic                   allowed,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    tbl_cfg_t cfg;

    // input register
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [TIME_BITS-1:0] in_time_reg;

    // bucket state
    logic [LEVEL_W-1:0]   token_level_reg;
    logic [LEVEL_W-1:0]   token_level_next;
    logic [TIME_BITS-1:0] last_grant_reg;
    logic [TIME_BITS-1:0] last_grant_next;

    // result register
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 allowed_reg;
    logic                 allowed_next;

    logic                 grant;
    logic [LEVEL_W-1:0]   level_after;
    logic                 res_free;
    logic                 fire;
    logic                 req_take;

    tbl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbl_refill #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_refill (
        .cfg             (cfg),
        .now             (in_time_reg),
        .last_grant_time (last_grant_reg),
        .token_level     (token_level_reg),
        .grant           (grant),
        .level_next      (level_after)
    );

    // The result register frees up when empty or when its transfer completes;
    // the held request then runs through the refill path and, if granted, updates the bucket.
    assign res_free  = !res_valid_reg || !res_stall;
    assign fire      = in_valid_reg && res_free;
    assign req_stall = in_valid_reg && !fire;
    assign req_take  = req_valid && !req_stall;

    assign res_valid = res_valid_reg;
    assign allowed   = allowed_reg;

    always_comb
    begin
        in_valid_next    = req_take || (in_valid_reg && !fire);
        res_valid_next   = fire || (res_valid_reg && res_stall);
        allowed_next     = fire ? grant : allowed_reg;
        token_level_next = token_level_reg;
        last_grant_next  = last_grant_reg;
        if (fire && grant)
        begin
            // take one token and advance the grant time
            token_level_next = level_after;
            last_grant_next  = in_time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            token_level_reg <= '0;
            last_grant_reg  <= '0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            res_valid_reg   <= res_valid_next;
            token_level_reg <= token_level_next;
            last_grant_reg  <= last_grant_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            in_time_reg <= request_time;
        allowed_reg <= allowed_next;
    end

    // a refused or absent request leaves the bucket alone
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && grant) |=> $stable(token_level_reg) && $stable(last_grant_reg))
        else $error("bucket state changed without a grant");

    // every processed request shows up as a result carrying its decision
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg && (allowed_reg == $past(grant)))
        else $error("result does not follow the processed request");

    // a grant records the request time
    a_grant_time: assert property (@(posedge clk) disable iff (!rst_n)
        fire && grant |=> last_grant_reg == $past(in_time_reg))
        else $error("grant time not recorded");

    // an accepted request is always held for processing
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> in_valid_reg)
        else $error("accepted request lost");

endmodule
